// File: rtl/sgrde_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and digit helpers for the SGR delta encoder.
// No dependencies; every other file of the block uses this package.
package sgrde_pkg;

    localparam int STYLE_W            = 7;
    localparam int COLOR_W            = 8;
    localparam int RGB_W              = 3 * COLOR_W;
    localparam int DEFAULT_FIFO_DEPTH = 4;

    // Reset tracking values
    localparam logic [STYLE_W-1:0] RESET_STYLE = 7'h00;
    localparam logic [RGB_W-1:0]   RESET_BACK  = 24'h000000;
    localparam logic [RGB_W-1:0]   RESET_FORE  = 24'hFFFFFF;

    // ASCII characters of the sequence
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic [STYLE_W-1:0] style_bits;
        logic [COLOR_W-1:0] back_red;
        logic [COLOR_W-1:0] back_green;
        logic [COLOR_W-1:0] back_blue;
        logic [COLOR_W-1:0] fore_red;
        logic [COLOR_W-1:0] fore_green;
        logic [COLOR_W-1:0] fore_blue;
        logic               force_colors;
        logic               restart_tracking;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_t;

    // Classified work handed from front to back
    typedef struct packed {
        logic [STYLE_W-1:0] diff_mask;
        logic [STYLE_W-1:0] new_style;
        logic               do_back;
        logic               do_fore;
        logic [RGB_W-1:0]   back_rgb;
        logic [RGB_W-1:0]   fore_rgb;
    } cmd_t;

    // On code of a style bit: bold, underline, italic, strike, blink, reverse, hidden
    function automatic logic [7:0] style_on_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_ONE;
            3'd1:    ch = CH_FOUR;
            3'd2:    ch = CH_THREE;
            3'd3:    ch = CH_NINE;
            3'd4:    ch = CH_FIVE;
            3'd5:    ch = CH_SEVEN;
            3'd6:    ch = CH_EIGHT;
            default: ch = CH_ONE;
        endcase
        return ch;
    endfunction

    // Second character of an off code; bold turns off with 22
    function automatic logic [7:0] style_off_char(input logic [2:0] idx);
        return (idx == 3'd0) ? CH_TWO : style_on_char(idx);
    endfunction

    // Index of the most significant decimal digit (0 ones, 1 tens, 2 hundreds)
    function automatic logic [1:0] digit_top(input logic [COLOR_W-1:0] v);
        logic [1:0] top;
        if (v >= 8'd100) begin
            top = 2'd2;
        end else if (v >= 8'd10) begin
            top = 2'd1;
        end else begin
            top = 2'd0;
        end
        return top;
    endfunction

    // One decimal digit of an 8-bit value; divide by ten through a reciprocal multiply
    function automatic logic [3:0] dec_digit(input logic [COLOR_W-1:0] v, input logic [1:0] pos);
        logic [15:0] p1;
        logic [4:0]  tens_all;
        logic [12:0] p2;
        logic [1:0]  hund;
        logic [7:0]  ones_w;
        logic [4:0]  tens_w;
        logic [3:0]  dig;
        p1       = {8'd0, v} * 16'd205;
        tens_all = p1[15:11];
        ones_w   = v - ({3'd0, tens_all} * 8'd10);
        p2       = {8'd0, tens_all} * 13'd205;
        hund     = p2[12:11];
        tens_w   = tens_all - ({3'd0, hund} * 5'd10);
        case (pos)
            2'd0:    dig = ones_w[3:0];
            2'd1:    dig = tens_w[3:0];
            default: dig = {2'b00, hund};
        endcase
        return dig;
    endfunction

endpackage

// File: rtl/sgr_delta_color_encoder_top.sv
`timescale 1ns / 1ps
// When idle, the first byte (ESC) of an accepted cell goes through the command queue, the
// sequencer's load into S_ESC and the output register before it shows on m_valid. The output
// sequencer moves one byte per cycle while m_ready holds, so a cell costs its sequence length
// (4 to 57 bytes), plus a load step when the sequencer was idle; an unchanged cell sends nothing.
// A FIFO_DEPTH-entry command queue lets input continue while the sequencer works.
// Reset (aresetn, synchronous, active low): style 0, background black, foreground
// white, queue empty, no output valid.
module sgr_delta_color_encoder_top #(
    parameter int FIFO_DEPTH = sgrde_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sgrde_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sgrde_pkg::out_t m_data
);

    logic            push;
    sgrde_pkg::cmd_t push_data;
    logic            fifo_full;
    logic            pop;
    sgrde_pkg::cmd_t pop_data;
    logic            fifo_not_empty;

    // Classify cells and keep tracking
    sgrde_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple classification from byte generation
    sgrde_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (fifo_not_empty)
    );

    // Emit escape sequence bytes
    sgrde_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_not_empty),
        .cmd_data  (pop_data),
        .cmd_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/sgrde_front.sv
`timescale 1ns / 1ps
// Front end: accepts cells, compares them with the tracked attributes, queues work.
// Depends on sgrde_pkg.
module sgrde_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sgrde_pkg::in_t    s_data,
    input  logic              fifo_full,
    output logic              push,
    output sgrde_pkg::cmd_t   push_data
);

    logic [sgrde_pkg::STYLE_W-1:0] tracked_style_reg, tracked_style_next;
    logic [sgrde_pkg::RGB_W-1:0]   tracked_back_reg, tracked_back_next;
    logic [sgrde_pkg::RGB_W-1:0]   tracked_fore_reg, tracked_fore_next;
    logic [sgrde_pkg::STYLE_W-1:0] base_style;
    logic [sgrde_pkg::RGB_W-1:0]   base_back;
    logic [sgrde_pkg::RGB_W-1:0]   base_fore;
    logic [sgrde_pkg::RGB_W-1:0]   cell_back;
    logic [sgrde_pkg::RGB_W-1:0]   cell_fore;
    logic [sgrde_pkg::STYLE_W-1:0] diff;
    logic                          do_back;
    logic                          do_fore;
    logic                          accept;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    // Compare against tracking, or against reset values on restart
    always_comb begin
        cell_back  = {s_data.back_red, s_data.back_green, s_data.back_blue};
        cell_fore  = {s_data.fore_red, s_data.fore_green, s_data.fore_blue};
        base_style = s_data.restart_tracking ? sgrde_pkg::RESET_STYLE : tracked_style_reg;
        base_back  = s_data.restart_tracking ? sgrde_pkg::RESET_BACK : tracked_back_reg;
        base_fore  = s_data.restart_tracking ? sgrde_pkg::RESET_FORE : tracked_fore_reg;
        diff       = s_data.style_bits ^ base_style;
        do_back    = s_data.force_colors || (cell_back != base_back);
        do_fore    = s_data.force_colors || (cell_fore != base_fore);
    end

    // Queue a command only when something changed
    always_comb begin
        push                = accept && ((diff != '0) || do_back || do_fore);
        push_data.diff_mask = diff;
        push_data.new_style = s_data.style_bits;
        push_data.do_back   = do_back;
        push_data.do_fore   = do_fore;
        push_data.back_rgb  = cell_back;
        push_data.fore_rgb  = cell_fore;
    end

    // Advance tracking on every accepted transaction
    always_comb begin
        tracked_style_next = tracked_style_reg;
        tracked_back_next  = tracked_back_reg;
        tracked_fore_next  = tracked_fore_reg;
        if (accept) begin
            tracked_style_next = s_data.style_bits;
            tracked_back_next  = do_back ? cell_back : base_back;
            tracked_fore_next  = do_fore ? cell_fore : base_fore;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracked_style_reg <= sgrde_pkg::RESET_STYLE;
            tracked_back_reg  <= sgrde_pkg::RESET_BACK;
            tracked_fore_reg  <= sgrde_pkg::RESET_FORE;
        end else begin
            tracked_style_reg <= tracked_style_next;
            tracked_back_reg  <= tracked_back_next;
            tracked_fore_reg  <= tracked_fore_next;
        end
    end

endmodule

// File: rtl/sgrde_fifo.sv
`timescale 1ns / 1ps
// Small command queue between front and back ends, register based.
// Depends on sgrde_pkg for the command type.
module sgrde_fifo #(
    parameter int DEPTH = sgrde_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sgrde_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output sgrde_pkg::cmd_t pop_data,
    output logic            not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sgrde_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sgrde_back.sv
`timescale 1ns / 1ps
// Back end: one command to SGR bytes in an output register, one byte per cycle unless stalled.
// Depends on sgrde_pkg.
module sgrde_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  sgrde_pkg::cmd_t cmd_data,
    output logic            cmd_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output sgrde_pkg::out_t m_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ESC   = 9'b000000010,
        S_BRK   = 9'b000000100,
        S_SEP   = 9'b000001000,
        S_CODE  = 9'b000010000,
        S_LEAD  = 9'b000100000,
        S_DIGIT = 9'b001000000,
        S_CSEP  = 9'b010000000,
        S_END   = 9'b100000000
    } seq_state_t;

    seq_state_t                    state_reg, state_next;
    logic [sgrde_pkg::STYLE_W-1:0] mask_reg, mask_next;
    logic [sgrde_pkg::STYLE_W-1:0] style_reg, style_next;
    logic                          db_reg, db_next;
    logic                          df_reg, df_next;
    logic [sgrde_pkg::RGB_W-1:0]   back_reg, back_next;
    logic [sgrde_pkg::RGB_W-1:0]   fore_reg, fore_next;
    logic [2:0]                    sub_reg, sub_next;
    logic [1:0]                    comp_reg, comp_next;
    logic [1:0]                    dpos_reg, dpos_next;
    logic                          out_valid_reg, out_valid_next;
    sgrde_pkg::out_t               out_reg, out_next;

    logic                          adv;
    logic                          emit;
    logic [7:0]                    byte_val;
    logic                          last_val;
    logic                          load;
    logic [2:0]                    bit_idx;
    logic                          bit_on;
    logic [sgrde_pkg::STYLE_W-1:0] mask_cleared;
    logic [sgrde_pkg::RGB_W-1:0]   color_sel;
    logic [sgrde_pkg::COLOR_W-1:0] comp_val;
    logic [sgrde_pkg::COLOR_W-1:0] next_comp_val;
    logic [7:0]                    code_char;
    logic [7:0]                    lead_char;

    // Choose what follows a finished token
    function automatic seq_state_t pick(input logic [sgrde_pkg::STYLE_W-1:0] mask,
                                        input logic db, input logic df, input logic sep);
        seq_state_t st;
        if ((mask == '0) && !db && !df) begin
            st = S_END;
        end else if (sep) begin
            st = S_SEP;
        end else if (mask != '0) begin
            st = S_CODE;
        end else begin
            st = S_LEAD;
        end
        return st;
    endfunction

    assign adv     = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign cmd_pop = load;

    // Lowest pending style bit and its code character
    always_comb begin
        bit_idx = 3'd0;
        for (int i = sgrde_pkg::STYLE_W - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                bit_idx = 3'(i);
            end
        end
        bit_on       = style_reg[bit_idx];
        mask_cleared = mask_reg & (mask_reg - 1'b1);
        if (bit_on) begin
            code_char = sgrde_pkg::style_on_char(bit_idx);
        end else if (sub_reg[0]) begin
            code_char = sgrde_pkg::style_off_char(bit_idx);
        end else begin
            code_char = sgrde_pkg::CH_TWO;
        end
    end

    // Active color group: background first while pending
    always_comb begin
        color_sel = db_reg ? back_reg : fore_reg;
        case (comp_reg)
            2'd0:    comp_val = color_sel[23:16];
            2'd1:    comp_val = color_sel[15:8];
            default: comp_val = color_sel[7:0];
        endcase
        next_comp_val = (comp_reg == 2'd0) ? color_sel[15:8] : color_sel[7:0];
        case (sub_reg)
            3'd0:    lead_char = db_reg ? sgrde_pkg::CH_FOUR : sgrde_pkg::CH_THREE;
            3'd1:    lead_char = sgrde_pkg::CH_EIGHT;
            3'd2:    lead_char = sgrde_pkg::CH_SEMI;
            3'd3:    lead_char = sgrde_pkg::CH_TWO;
            default: lead_char = sgrde_pkg::CH_SEMI;
        endcase
    end

    // Byte sequencer
    always_comb begin
        state_next = state_reg;
        mask_next  = mask_reg;
        style_next = style_reg;
        db_next    = db_reg;
        df_next    = df_reg;
        back_next  = back_reg;
        fore_next  = fore_reg;
        sub_next   = sub_reg;
        comp_next  = comp_reg;
        dpos_next  = dpos_reg;
        emit       = 1'b0;
        byte_val   = sgrde_pkg::CH_ZERO;
        last_val   = 1'b0;
        load       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    load       = 1'b1;
                    state_next = S_ESC;
                end
            end
            S_ESC: begin
                if (adv) begin
                    emit       = 1'b1;
                    byte_val   = sgrde_pkg::CH_ESC;
                    state_next = S_BRK;
                end
            end
            S_BRK: begin
                if (adv) begin
                    emit       = 1'b1;
                    byte_val   = sgrde_pkg::CH_BRACKET;
                    sub_next   = '0;
                    state_next = pick(mask_reg, db_reg, df_reg, 1'b0);
                end
            end
            S_SEP: begin
                if (adv) begin
                    emit       = 1'b1;
                    byte_val   = sgrde_pkg::CH_SEMI;
                    sub_next   = '0;
                    state_next = (mask_reg != '0) ? S_CODE : S_LEAD;
                end
            end
            S_CODE: begin
                if (adv) begin
                    emit     = 1'b1;
                    byte_val = code_char;
                    if (bit_on || sub_reg[0]) begin
                        mask_next  = mask_cleared;
                        sub_next   = '0;
                        state_next = pick(mask_cleared, db_reg, df_reg, 1'b1);
                    end else begin
                        sub_next = 3'd1;
                    end
                end
            end
            S_LEAD: begin
                if (adv) begin
                    emit     = 1'b1;
                    byte_val = lead_char;
                    if (sub_reg == 3'd4) begin
                        comp_next  = 2'd0;
                        dpos_next  = sgrde_pkg::digit_top(color_sel[23:16]);
                        state_next = S_DIGIT;
                    end else begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
            end
            S_DIGIT: begin
                if (adv) begin
                    emit     = 1'b1;
                    byte_val = sgrde_pkg::CH_ZERO
                             + {4'd0, sgrde_pkg::dec_digit(comp_val, dpos_reg)};
                    if (dpos_reg != 2'd0) begin
                        dpos_next = dpos_reg - 1'b1;
                    end else if (comp_reg == 2'd2) begin
                        sub_next = '0;
                        if (db_reg) begin
                            db_next    = 1'b0;
                            state_next = pick(mask_reg, 1'b0, df_reg, 1'b1);
                        end else begin
                            df_next    = 1'b0;
                            state_next = pick(mask_reg, 1'b0, 1'b0, 1'b1);
                        end
                    end else begin
                        state_next = S_CSEP;
                    end
                end
            end
            S_CSEP: begin
                if (adv) begin
                    emit       = 1'b1;
                    byte_val   = sgrde_pkg::CH_SEMI;
                    comp_next  = comp_reg + 1'b1;
                    dpos_next  = sgrde_pkg::digit_top(next_comp_val);
                    state_next = S_DIGIT;
                end
            end
            S_END: begin
                if (adv) begin
                    emit     = 1'b1;
                    byte_val = sgrde_pkg::CH_M;
                    last_val = 1'b1;
                    if (cmd_valid) begin
                        load       = 1'b1;
                        state_next = S_ESC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // Take the next command from the queue
        if (load) begin
            mask_next  = cmd_data.diff_mask;
            style_next = cmd_data.new_style;
            db_next    = cmd_data.do_back;
            df_next    = cmd_data.do_fore;
            back_next  = cmd_data.back_rgb;
            fore_next  = cmd_data.fore_rgb;
        end
    end

    // Output register: drop valid when taken and nothing new follows
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (adv) begin
            out_valid_next     = emit;
            out_next.out_byte  = byte_val;
            out_next.last_byte = last_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload and working registers
    always_ff @(posedge aclk) begin
        mask_reg  <= mask_next;
        style_reg <= style_next;
        db_reg    <= db_next;
        df_reg    <= df_next;
        back_reg  <= back_next;
        fore_reg  <= fore_next;
        sub_reg   <= sub_next;
        comp_reg  <= comp_next;
        dpos_reg  <= dpos_next;
        out_reg   <= out_next;
    end

endmodule

// File: rtl/sgrde_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the SGR delta encoder output stream, with its bind statement.
// Depends on sgrde_pkg and sgr_delta_color_encoder_top.
module sgrde_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input sgrde_pkg::out_t m_data
);

    logic start_reg, start_next;
    logic esc_seen_reg, esc_seen_next;
    logic out_take;

    assign out_take = m_valid && m_ready;

    // Track sequence boundaries from completed output transactions
    always_comb begin
        start_next    = start_reg;
        esc_seen_next = esc_seen_reg;
        if (out_take) begin
            start_next    = m_data.last_byte;
            esc_seen_next = (m_data.out_byte == sgrde_pkg::CH_ESC);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= 1'b1;
            esc_seen_reg <= 1'b0;
        end else begin
            start_reg    <= start_next;
            esc_seen_reg <= esc_seen_next;
        end
    end

    // A stalled output transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed while stalled");

    // Every sequence opens with ESC
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && start_reg |-> m_data.out_byte == sgrde_pkg::CH_ESC)
        else $error("sequence does not start with ESC");

    // ESC is followed by the bracket
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && esc_seen_reg |-> m_data.out_byte == sgrde_pkg::CH_BRACKET && !m_data.last_byte)
        else $error("ESC not followed by bracket");

    // Only the final m carries the last flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_byte |-> m_data.out_byte == sgrde_pkg::CH_M)
        else $error("last flag on a byte other than m");

    // Reset clears the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind sgr_delta_color_encoder_top sgrde_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sgr_delta_color_encoder_top: directed cells, then random cells.
// Depends on sgrde_pkg for the transaction types and character constants.
module tb_top;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_CELLS = 262;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    sgrde_pkg::in_t  s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    sgrde_pkg::out_t m_data;

    // Style code text per bit: bold, underline, italic, strike, blink, reverse, hidden
    string style_on_code[sgrde_pkg::STYLE_W]  = '{"1", "4", "3", "9", "5", "7", "8"};
    string style_off_code[sgrde_pkg::STYLE_W] = '{"22", "24", "23", "29", "25", "27", "28"};
    string back_lead = "48;2;";
    string fore_lead = "38;2;";

    // Attribute tracking mirrored by the encoder model
    logic [sgrde_pkg::STYLE_W-1:0] trk_style = sgrde_pkg::RESET_STYLE;
    logic [sgrde_pkg::RGB_W-1:0]   trk_back  = sgrde_pkg::RESET_BACK;
    logic [sgrde_pkg::RGB_W-1:0]   trk_fore  = sgrde_pkg::RESET_FORE;
    logic [7:0]                    sgr_bytes[$];

    // Expected output bytes, oldest first, and per-cell notes from the driver
    sgrde_pkg::out_t expected_bytes[$];
    bit              note_typed[$];
    string           note_tail[$];

    // Directed stimulus table
    sgrde_pkg::in_t dir_cells[$];
    bit             dir_typed[$];
    string          dir_tails[$];

    int cells_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    sgr_delta_color_encoder_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Append one byte to the predicted sequence
    function automatic void put_byte(input logic [7:0] b);
        sgr_bytes.insert(sgr_bytes.size(), b);
    endfunction

    // Append the characters of a code string
    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    // Append a color component in decimal without leading zeros
    function automatic void put_dec(input logic [7:0] v);
        if (v >= 8'd100) put_byte(sgrde_pkg::CH_ZERO + v / 8'd100);
        if (v >= 8'd10) put_byte(sgrde_pkg::CH_ZERO + (v / 8'd10) % 8'd10);
        put_byte(sgrde_pkg::CH_ZERO + v % 8'd10);
    endfunction

    function automatic void put_color(input string lead,
                                      input logic [sgrde_pkg::RGB_W-1:0] rgb);
        put_text(lead);
        put_dec(rgb[23:16]);
        put_byte(sgrde_pkg::CH_SEMI);
        put_dec(rgb[15:8]);
        put_byte(sgrde_pkg::CH_SEMI);
        put_dec(rgb[7:0]);
    endfunction

    // Build the SGR sequence for one cell into sgr_bytes and advance the tracking
    function automatic void encode_cell(input sgrde_pkg::in_t c);
        logic [sgrde_pkg::RGB_W-1:0] back;
        logic [sgrde_pkg::RGB_W-1:0] fore;
        logic                        do_back;
        logic                        do_fore;
        logic                        sep;
        back = {c.back_red, c.back_green, c.back_blue};
        fore = {c.fore_red, c.fore_green, c.fore_blue};
        sgr_bytes.delete();
        if (c.restart_tracking) begin
            trk_style = sgrde_pkg::RESET_STYLE;
            trk_back  = sgrde_pkg::RESET_BACK;
            trk_fore  = sgrde_pkg::RESET_FORE;
        end
        do_back = c.force_colors || back != trk_back;
        do_fore = c.force_colors || fore != trk_fore;
        if (c.style_bits == trk_style && !do_back && !do_fore) return;
        put_byte(sgrde_pkg::CH_ESC);
        put_byte(sgrde_pkg::CH_BRACKET);
        sep = 1'b0;
        for (int i = 0; i < sgrde_pkg::STYLE_W; i++) begin
            if (c.style_bits[i] != trk_style[i]) begin
                if (sep) put_byte(sgrde_pkg::CH_SEMI);
                put_text(c.style_bits[i] ? style_on_code[i] : style_off_code[i]);
                sep = 1'b1;
            end
        end
        trk_style = c.style_bits;
        if (do_back) begin
            if (sep) put_byte(sgrde_pkg::CH_SEMI);
            put_color(back_lead, back);
            sep = 1'b1;
            trk_back = back;
        end
        if (do_fore) begin
            if (sep) put_byte(sgrde_pkg::CH_SEMI);
            put_color(fore_lead, fore);
            trk_fore = fore;
        end
        put_byte(sgrde_pkg::CH_M);
    endfunction

    function automatic sgrde_pkg::in_t mk_cell(input logic [6:0] style,
                                               input logic [23:0] back,
                                               input logic [23:0] fore, input bit force_c,
                                               input bit restart);
        sgrde_pkg::in_t c;
        c.style_bits       = style;
        {c.back_red, c.back_green, c.back_blue} = back;
        {c.fore_red, c.fore_green, c.fore_blue} = fore;
        c.force_colors     = force_c;
        c.restart_tracking = restart;
        return c;
    endfunction

    // An empty typed tail means the cell sends nothing
    function automatic void table_row(input sgrde_pkg::in_t c, input bit typed,
                                      input string tail);
        dir_cells.insert(dir_cells.size(), c);
        dir_typed.insert(dir_typed.size(), typed);
        dir_tails.insert(dir_tails.size(), tail);
    endfunction

    // Favor decimal digit-count boundaries
    function automatic logic [7:0] pick_level();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'd0;
            1:       v = 8'd9;
            2:       v = 8'd10;
            3:       v = 8'd99;
            4:       v = 8'd100;
            5:       v = 8'd255;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Offer one cell and hold it until accepted, then, unless calm, idle at random
    task automatic send_cell(input sgrde_pkg::in_t c, input bit typed, input string tail,
                             input bit calm);
        note_typed.insert(note_typed.size(), typed);
        note_tail.insert(note_tail.size(), tail);
        s_data  <= c;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 35) @(posedge aclk);
        end
    endtask

    // Check output transactions, then predict for accepted cells
    always @(posedge aclk) begin : monitor
        sgrde_pkg::out_t want;
        bit              typed;
        string           tail;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: no byte expected, actual %h", m_data.out_byte);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h", want.out_byte,
                               m_data.out_byte);
                        mismatches++;
                    end
                    if (m_data.last_byte !== want.last_byte) begin
                        $error("last_byte: expected %b, actual %b", want.last_byte,
                               m_data.last_byte);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                typed = note_typed.pop_front();
                tail  = note_tail.pop_front();
                encode_cell(s_data);
                // Replace the model's bytes with the hand-written sequence
                if (typed) begin
                    sgr_bytes.delete();
                    if (tail.len() != 0) begin
                        put_byte(sgrde_pkg::CH_ESC);
                        put_byte(sgrde_pkg::CH_BRACKET);
                        put_text(tail);
                    end
                end
                for (int i = 0; i < sgr_bytes.size(); i++) begin
                    want.out_byte  = sgr_bytes[i];
                    want.last_byte = (i == sgr_bytes.size() - 1);
                    expected_bytes.insert(expected_bytes.size(), want);
                end
                cells_accepted++;
            end
        end
    end

    // Output backpressure: random stalls, one long hold-off, one calm stretch
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && cells_accepted >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (cells_accepted >= 200 && cells_accepted < 260) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : driver
        sgrde_pkg::in_t c;
        sgrde_pkg::in_t prev;
        int             n;
        // Directed cells; tracking starts at style 0, black background, white foreground
        table_row(mk_cell(7'h00, 24'h000000, 24'hFFFFFF, 0, 0), 1, "");
        table_row(mk_cell(7'h01, 24'h000000, 24'hFFFFFF, 0, 0), 1, "1m");
        table_row(mk_cell(7'h7F, 24'h000000, 24'hFFFFFF, 0, 0), 1, "4;3;9;5;7;8m");
        table_row(mk_cell(7'h00, 24'h000000, 24'hFFFFFF, 0, 0), 1, "22;24;23;29;25;27;28m");
        table_row(mk_cell(7'h00, 24'hFFFFFF, 24'hFFFFFF, 0, 0), 1, "48;2;255;255;255m");
        table_row(mk_cell(7'h00, 24'hFFFFFF, 24'h000000, 0, 0), 1, "38;2;0;0;0m");
        table_row(mk_cell(7'h00, 24'hFFFFFF, 24'h000000, 1, 0), 1,
                  "48;2;255;255;255;38;2;0;0;0m");
        table_row(mk_cell(7'h00, 24'hFFFFFF, 24'h000000, 0, 1), 1,
                  "48;2;255;255;255;38;2;0;0;0m");
        table_row(mk_cell(7'h00, 24'h000000, 24'hFFFFFF, 0, 1), 1, "");
        table_row(mk_cell(7'h55, 24'h0A0963, 24'h6400FF, 0, 0), 0, "");
        table_row(mk_cell(7'h2A, 24'h0A0963, 24'h6400FF, 0, 0), 0, "");
        table_row(mk_cell(7'h2A, 24'h0A0963, 24'h6400FF, 1, 0), 0, "");
        table_row(mk_cell(7'h7F, 24'h808080, 24'h7F7F7F, 0, 0), 0, "");
        table_row(mk_cell(7'h00, 24'hFFFFFF, 24'hC8C8C8, 0, 0), 0, "");
        table_row(mk_cell(7'h03, 24'h010203, 24'hFFFFFF, 1, 1), 0, "");
        table_row(mk_cell(7'h03, 24'h010203, 24'hFFFFFF, 0, 0), 0, "");
        table_row(mk_cell(7'h0B, 24'h010203, 24'hFFFFFF, 0, 0), 0, "");
        table_row(mk_cell(7'h40, 24'h64090A, 24'h0A6309, 0, 1), 0, "");

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < dir_cells.size(); i++) begin
            send_cell(dir_cells[i], dir_typed[i], dir_tails[i], 1'b0);
        end
        prev = dir_cells[dir_cells.size() - 1];

        // Random cells derived from the previous one, so repeats and small deltas occur
        for (n = 0; n < RANDOM_CELLS; n++) begin
            c = prev;
            c.force_colors     = 1'b0;
            c.restart_tracking = 1'b0;
            if ($urandom_range(0, 99) >= 12) begin
                case ($urandom_range(0, 3))
                    0:       c.style_bits = prev.style_bits;
                    1:       c.style_bits = prev.style_bits ^ (7'd1 << $urandom_range(0, 6));
                    default: c.style_bits = 7'($urandom_range(0, 127));
                endcase
                if ($urandom_range(0, 1))
                    {c.back_red, c.back_green, c.back_blue} =
                        {pick_level(), pick_level(), pick_level()};
                if ($urandom_range(0, 1))
                    {c.fore_red, c.fore_green, c.fore_blue} =
                        {pick_level(), pick_level(), pick_level()};
                c.force_colors     = ($urandom_range(0, 99) < 15);
                c.restart_tracking = ($urandom_range(0, 99) < 6);
            end else if ($urandom_range(0, 3) == 0) begin
                c.restart_tracking = 1'b1;
            end
            send_cell(c, 1'b0, "", n >= 120 && n < 180);
            prev = c;
        end
        s_valid <= 1'b0;

        // Drain outstanding bytes, then allow the pipeline to settle
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
